FILE: rtl/sdsh_pkg.sv
`timescale 1ns / 1ps
package sdsh_pkg;

    localparam int unsigned SECTOR_BYTES   = 512;
    localparam int unsigned PREAMBLE_BYTES = 100;

    typedef enum logic [4:0] {
        PH_IDLE, PH_PRE, PH_CGAP, PH_CLEAD, PH_CBYTE, PH_CPOLL, PH_CEXTRA, PH_CEND,
        PH_XPRE, PH_XBYTE, PH_XPOLL, PH_RTOK, PH_RDATA, PH_RCRC,
        PH_WTOK, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY
    } phase_t;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_INIT  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_WRITE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CMD_GO_IDLE = 3'd0,
        CMD_IF_COND = 3'd1,
        CMD_APP     = 3'd2,
        CMD_ACTIVATE = 3'd3,
        CMD_READ_OCR = 3'd4,
        CMD_BLOCKLEN = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CMD_POLL   = 3'd0,
        REG_RW_POLL    = 3'd1,
        REG_TOKEN_POLL = 3'd2,
        REG_BUSY_POLL  = 3'd3,
        REG_RESET_RETRY = 3'd4,
        REG_ACT_RETRY  = 3'd5,
        REG_DATA_RESP  = 3'd6
    } reg_idx_t;

    // Configuration register contents shared between the register block and the core.
    typedef struct packed {
        logic [15:0] cmd_poll_limit;
        logic [15:0] rw_poll_limit;
        logic [19:0] token_poll_limit;
        logic [19:0] busy_poll_limit;
        logic [11:0] reset_retry_limit;
        logic [7:0]  activate_retry_limit;
        logic [7:0]  data_resp_limit;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       cs_level;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       wr_taken;
        logic       op_done;
        logic       op_status;
        logic       card_ready;
        logic       card_v2;
    } result_t;

    // Byte k (0 to 5) of an initialisation command frame.
    function automatic logic [7:0] init_cmd_byte(input logic [2:0] cmd, input logic [2:0] k);
        logic [7:0]  code;
        logic [31:0] arg;
        logic [7:0]  crc;
        logic [7:0]  res;
        code = 8'd0;
        arg  = 32'd0;
        crc  = 8'hFF;
        case (cmd)
            CMD_GO_IDLE:  begin code = 8'd0;  crc = 8'h95; end
            CMD_IF_COND:  begin code = 8'd8;  arg = 32'h0000_01AA; crc = 8'h87; end
            CMD_APP:      code = 8'd55;
            CMD_ACTIVATE: begin code = 8'd41; arg = 32'h4000_0000; end
            CMD_READ_OCR: code = 8'd58;
            default:      begin code = 8'd16; arg = 32'(SECTOR_BYTES); end
        endcase
        case (k)
            3'd0:    res = 8'h40 | code;
            3'd1:    res = arg[31:24];
            3'd2:    res = arg[23:16];
            3'd3:    res = arg[15:8];
            3'd4:    res = arg[7:0];
            default: res = crc;
        endcase
        return res;
    endfunction

    // Byte k of a read or write command frame.
    function automatic logic [7:0] rw_cmd_byte(input logic wr, input logic [31:0] addr,
                                               input logic [2:0] k);
        logic [7:0] res;
        case (k)
            3'd0:    res = wr ? 8'h58 : 8'h51;
            3'd1:    res = addr[31:24];
            3'd2:    res = addr[23:16];
            3'd3:    res = addr[15:8];
            3'd4:    res = addr[7:0];
            default: res = 8'hFF;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/sdsh_regs.sv
`timescale 1ns / 1ps
module sdsh_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output sdsh_pkg::cfg_t       cfg
);

    sdsh_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // Register writes on the access phase of a transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cmd_poll_limit       <= 16'd1000;
            cfg_reg.rw_poll_limit        <= 16'd10000;
            cfg_reg.token_poll_limit     <= 20'd1000000;
            cfg_reg.busy_poll_limit      <= 20'd500000;
            cfg_reg.reset_retry_limit    <= 12'd4095;
            cfg_reg.activate_retry_limit <= 8'd5;
            cfg_reg.data_resp_limit      <= 8'd20;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                sdsh_pkg::REG_CMD_POLL:    cfg_reg.cmd_poll_limit       <= pwdata[15:0];
                sdsh_pkg::REG_RW_POLL:     cfg_reg.rw_poll_limit        <= pwdata[15:0];
                sdsh_pkg::REG_TOKEN_POLL:  cfg_reg.token_poll_limit     <= pwdata[19:0];
                sdsh_pkg::REG_BUSY_POLL:   cfg_reg.busy_poll_limit      <= pwdata[19:0];
                sdsh_pkg::REG_RESET_RETRY: cfg_reg.reset_retry_limit    <= pwdata[11:0];
                sdsh_pkg::REG_ACT_RETRY:   cfg_reg.activate_retry_limit <= pwdata[7:0];
                sdsh_pkg::REG_DATA_RESP:   cfg_reg.data_resp_limit      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (idx)
            sdsh_pkg::REG_CMD_POLL:    prdata = {16'd0, cfg_reg.cmd_poll_limit};
            sdsh_pkg::REG_RW_POLL:     prdata = {16'd0, cfg_reg.rw_poll_limit};
            sdsh_pkg::REG_TOKEN_POLL:  prdata = {12'd0, cfg_reg.token_poll_limit};
            sdsh_pkg::REG_BUSY_POLL:   prdata = {12'd0, cfg_reg.busy_poll_limit};
            sdsh_pkg::REG_RESET_RETRY: prdata = {20'd0, cfg_reg.reset_retry_limit};
            sdsh_pkg::REG_ACT_RETRY:   prdata = {24'd0, cfg_reg.activate_retry_limit};
            sdsh_pkg::REG_DATA_RESP:   prdata = {24'd0, cfg_reg.data_resp_limit};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/sdsh_core.sv
`timescale 1ns / 1ps
module sdsh_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [1:0]          req_type,
    input  logic [31:0]         sector,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          wr_byte,
    input  sdsh_pkg::cfg_t      cfg,
    output sdsh_pkg::result_t   res
);

    localparam logic [9:0] LAST_IDX = 10'(sdsh_pkg::SECTOR_BYTES - 1);
    localparam logic [9:0] PRE_LAST = 10'(sdsh_pkg::PREAMBLE_BYTES - 1);

    sdsh_pkg::phase_t phase_reg, phase_next;
    logic [9:0]  idx_reg, idx_next;
    logic [19:0] poll_reg, poll_next;
    logic [11:0] retry_reg, retry_next;
    logic        ready_reg, ready_next;
    logic        v2_reg, v2_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  lastr_reg, lastr_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic        wr_reg, wr_next;

    logic [19:0] poll_inc;
    logic [11:0] retry_inc;
    logic [7:0]  resp;
    logic        cmd_fin;
    logic        op_end;
    logic        op_err;

    assign poll_inc  = poll_reg + 20'd1;
    assign retry_inc = retry_reg + 12'd1;

    // State registers; one step per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sdsh_pkg::PH_IDLE;
            idx_reg   <= '0;
            poll_reg  <= '0;
            retry_reg <= '0;
            ready_reg <= 1'b0;
            v2_reg    <= 1'b0;
            addr_reg  <= '0;
            lastr_reg <= 8'hFF;
            cmd_reg   <= '0;
            wr_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            poll_reg  <= poll_next;
            retry_reg <= retry_next;
            ready_reg <= ready_next;
            v2_reg    <= v2_next;
            addr_reg  <= addr_next;
            lastr_reg <= lastr_next;
            cmd_reg   <= cmd_next;
            wr_reg    <= wr_next;
        end
    end

    // Next state of one byte exchange, and whether it ends the operation.
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        poll_next  = poll_reg;
        retry_next = retry_reg;
        ready_next = ready_reg;
        v2_next    = v2_reg;
        addr_next  = addr_reg;
        lastr_next = lastr_reg;
        cmd_next   = cmd_reg;
        wr_next    = wr_reg;
        resp       = lastr_reg;
        cmd_fin    = 1'b0;
        op_end     = 1'b0;
        op_err     = 1'b0;

        case (req_type)
            sdsh_pkg::REQ_INIT:
            begin
                if (ready_reg)
                begin
                    op_end     = 1'b1;
                    phase_next = sdsh_pkg::PH_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    retry_next = '0;
                    phase_next = sdsh_pkg::PH_PRE;
                    idx_next   = '0;
                end
            end
            sdsh_pkg::REQ_READ, sdsh_pkg::REQ_WRITE:
            begin
                if (!ready_reg)
                begin
                    op_end     = 1'b1;
                    op_err     = 1'b1;
                    phase_next = sdsh_pkg::PH_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    wr_next    = (req_type == sdsh_pkg::REQ_WRITE);
                    addr_next  = v2_reg ? sector : {sector[22:0], 9'd0};
                    phase_next = sdsh_pkg::PH_XPRE;
                    idx_next   = '0;
                end
            end
            default:
            begin
                unique case (phase_reg)
                    sdsh_pkg::PH_PRE:
                    begin
                        if (idx_reg < PRE_LAST)
                            idx_next = idx_reg + 10'd1;
                        else
                        begin
                            retry_next = '0;
                            cmd_next   = sdsh_pkg::CMD_GO_IDLE;
                            phase_next = sdsh_pkg::PH_CGAP;
                            idx_next   = '0;
                        end
                    end
                    sdsh_pkg::PH_CGAP:
                    begin
                        if (idx_reg < 10'd7)
                            idx_next = idx_reg + 10'd1;
                        else
                        begin
                            phase_next = sdsh_pkg::PH_CLEAD;
                            idx_next   = '0;
                        end
                    end
                    sdsh_pkg::PH_CLEAD:
                    begin
                        phase_next = sdsh_pkg::PH_CBYTE;
                        idx_next   = '0;
                    end
                    sdsh_pkg::PH_CBYTE:
                    begin
                        if (idx_reg < 10'd5)
                            idx_next = idx_reg + 10'd1;
                        else
                        begin
                            poll_next  = '0;
                            phase_next = sdsh_pkg::PH_CPOLL;
                            idx_next   = '0;
                        end
                    end
                    sdsh_pkg::PH_CPOLL:
                    begin
                        if (rx_byte != 8'hFF)
                            cmd_fin = 1'b1;
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= {4'd0, cfg.cmd_poll_limit})
                                cmd_fin = 1'b1;
                        end
                        if (cmd_fin)
                        begin
                            resp       = rx_byte;
                            lastr_next = rx_byte;
                            if ((cmd_reg == sdsh_pkg::CMD_IF_COND && rx_byte == 8'h01) ||
                                (cmd_reg == sdsh_pkg::CMD_READ_OCR && rx_byte == 8'h00))
                            begin
                                cmd_fin    = 1'b0;
                                phase_next = sdsh_pkg::PH_CEXTRA;
                                idx_next   = '0;
                            end
                        end
                    end
                    sdsh_pkg::PH_CEXTRA:
                    begin
                        if (idx_reg < 10'd3)
                            idx_next = idx_reg + 10'd1;
                        else
                            cmd_fin = 1'b1;
                    end
                    sdsh_pkg::PH_CEND:
                    begin
                        phase_next = sdsh_pkg::PH_CGAP;
                        idx_next   = '0;
                    end
                    sdsh_pkg::PH_XPRE:
                    begin
                        phase_next = sdsh_pkg::PH_XBYTE;
                        idx_next   = '0;
                    end
                    sdsh_pkg::PH_XBYTE:
                    begin
                        if (idx_reg < 10'd5)
                            idx_next = idx_reg + 10'd1;
                        else
                        begin
                            poll_next  = '0;
                            phase_next = sdsh_pkg::PH_XPOLL;
                            idx_next   = '0;
                        end
                    end
                    sdsh_pkg::PH_XPOLL:
                    begin
                        if (!rx_byte[7])
                        begin
                            lastr_next = rx_byte;
                            if (rx_byte != 8'h00)
                            begin
                                op_end = 1'b1;
                                op_err = 1'b1;
                            end
                            else if (wr_reg)
                            begin
                                phase_next = sdsh_pkg::PH_WTOK;
                                idx_next   = '0;
                            end
                            else
                            begin
                                poll_next  = '0;
                                phase_next = sdsh_pkg::PH_RTOK;
                                idx_next   = '0;
                            end
                        end
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= {4'd0, cfg.rw_poll_limit})
                            begin
                                lastr_next = 8'hFF;
                                op_end     = 1'b1;
                                op_err     = 1'b1;
                            end
                        end
                    end
                    sdsh_pkg::PH_RTOK:
                    begin
                        if (rx_byte != 8'hFF)
                        begin
                            if (rx_byte == 8'hFE)
                            begin
                                phase_next = sdsh_pkg::PH_RDATA;
                                idx_next   = '0;
                            end
                            else
                            begin
                                op_end = 1'b1;
                                op_err = 1'b1;
                            end
                        end
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= cfg.token_poll_limit)
                            begin
                                op_end = 1'b1;
                                op_err = 1'b1;
                            end
                        end
                    end
                    sdsh_pkg::PH_RDATA:
                    begin
                        if (idx_reg < LAST_IDX)
                            idx_next = idx_reg + 10'd1;
                        else
                        begin
                            phase_next = sdsh_pkg::PH_RCRC;
                            idx_next   = '0;
                        end
                    end
                    sdsh_pkg::PH_RCRC:
                    begin
                        if (idx_reg == 10'd0)
                            idx_next = 10'd1;
                        else
                            op_end = 1'b1;
                    end
                    sdsh_pkg::PH_WTOK:
                    begin
                        phase_next = sdsh_pkg::PH_WDATA;
                        idx_next   = '0;
                    end
                    sdsh_pkg::PH_WDATA:
                    begin
                        if (idx_reg < LAST_IDX)
                            idx_next = idx_reg + 10'd1;
                        else
                        begin
                            phase_next = sdsh_pkg::PH_WCRC;
                            idx_next   = '0;
                        end
                    end
                    sdsh_pkg::PH_WCRC:
                    begin
                        if (idx_reg == 10'd0)
                            idx_next = 10'd1;
                        else
                        begin
                            poll_next  = '0;
                            phase_next = sdsh_pkg::PH_WRESP;
                            idx_next   = '0;
                        end
                    end
                    sdsh_pkg::PH_WRESP:
                    begin
                        if (rx_byte != 8'hFF)
                        begin
                            if (rx_byte[4:0] == 5'h05)
                            begin
                                poll_next  = '0;
                                phase_next = sdsh_pkg::PH_WBUSY;
                                idx_next   = '0;
                            end
                            else
                            begin
                                op_end = 1'b1;
                                op_err = 1'b1;
                            end
                        end
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= {12'd0, cfg.data_resp_limit})
                            begin
                                op_end = 1'b1;
                                op_err = 1'b1;
                            end
                        end
                    end
                    sdsh_pkg::PH_WBUSY:
                    begin
                        if (rx_byte != 8'h00)
                            op_end = 1'b1;
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= cfg.busy_poll_limit)
                            begin
                                op_end = 1'b1;
                                op_err = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = sdsh_pkg::PH_IDLE;
                        idx_next   = '0;
                    end
                endcase

                // Conclusion of an initialisation command from its response.
                if (cmd_fin)
                begin
                    phase_next = sdsh_pkg::PH_CEND;
                    idx_next   = '0;
                    case (cmd_reg)
                        sdsh_pkg::CMD_GO_IDLE:
                        begin
                            if (resp == 8'h01)
                                cmd_next = sdsh_pkg::CMD_IF_COND;
                            else
                            begin
                                retry_next = retry_inc;
                                if (retry_inc >= cfg.reset_retry_limit)
                                begin
                                    op_end = 1'b1;
                                    op_err = 1'b1;
                                end
                            end
                        end
                        sdsh_pkg::CMD_IF_COND:
                        begin
                            if (resp == 8'h05 || resp == 8'h01)
                            begin
                                v2_next    = (resp == 8'h01);
                                retry_next = '0;
                                cmd_next   = sdsh_pkg::CMD_APP;
                            end
                            else
                            begin
                                op_end = 1'b1;
                                op_err = 1'b1;
                            end
                        end
                        sdsh_pkg::CMD_APP:
                            cmd_next = sdsh_pkg::CMD_ACTIVATE;
                        sdsh_pkg::CMD_ACTIVATE:
                        begin
                            if (resp == 8'h00)
                                cmd_next = sdsh_pkg::CMD_READ_OCR;
                            else if (resp == 8'h01)
                            begin
                                retry_next = retry_inc;
                                if (retry_inc >= {4'd0, cfg.activate_retry_limit})
                                begin
                                    op_end = 1'b1;
                                    op_err = 1'b1;
                                end
                                else
                                    cmd_next = sdsh_pkg::CMD_APP;
                            end
                            else
                            begin
                                op_end = 1'b1;
                                op_err = 1'b1;
                            end
                        end
                        sdsh_pkg::CMD_READ_OCR:
                        begin
                            if (resp == 8'h00)
                                cmd_next = sdsh_pkg::CMD_BLOCKLEN;
                            else
                            begin
                                op_end = 1'b1;
                                op_err = 1'b1;
                            end
                        end
                        default:
                        begin
                            op_end = 1'b1;
                            if (resp == 8'h00)
                                ready_next = 1'b1;
                            else
                                op_err = 1'b1;
                        end
                    endcase
                end

                // Every finishing exchange returns the sequencer to idle.
                if (op_end)
                begin
                    phase_next = sdsh_pkg::PH_IDLE;
                    idx_next   = '0;
                end
            end
        endcase
    end

    // Result of the exchange: the byte to send follows from the phase being entered.
    always_comb
    begin
        res          = '0;
        res.tx_byte  = 8'hFF;
        res.cs_level = 1'b1;

        if (op_end)
        begin
            res.op_done   = 1'b1;
            res.op_status = op_err;
        end
        else
        begin
            unique case (phase_next)
                sdsh_pkg::PH_CLEAD, sdsh_pkg::PH_CPOLL, sdsh_pkg::PH_CEXTRA,
                sdsh_pkg::PH_XPOLL, sdsh_pkg::PH_RTOK, sdsh_pkg::PH_RDATA,
                sdsh_pkg::PH_RCRC, sdsh_pkg::PH_WRESP, sdsh_pkg::PH_WBUSY:
                    res.cs_level = 1'b0;
                sdsh_pkg::PH_CBYTE:
                begin
                    res.tx_byte  = sdsh_pkg::init_cmd_byte(cmd_reg, idx_next[2:0]);
                    res.cs_level = 1'b0;
                end
                sdsh_pkg::PH_XBYTE:
                begin
                    res.tx_byte  = sdsh_pkg::rw_cmd_byte(wr_reg, addr_reg, idx_next[2:0]);
                    res.cs_level = 1'b0;
                end
                sdsh_pkg::PH_WTOK:
                begin
                    res.tx_byte  = 8'hFE;
                    res.cs_level = 1'b0;
                end
                sdsh_pkg::PH_WDATA:
                begin
                    res.tx_byte  = wr_byte;
                    res.cs_level = 1'b0;
                    res.wr_taken = 1'b1;
                end
                sdsh_pkg::PH_WCRC:
                begin
                    res.tx_byte  = 8'h00;
                    res.cs_level = 1'b0;
                end
                default:
                    ;
            endcase
        end

        // Sector data arrives on every card byte of the data phase.
        if (req_type == sdsh_pkg::REQ_BYTE && phase_reg == sdsh_pkg::PH_RDATA)
        begin
            res.rd_valid = 1'b1;
            res.rd_byte  = rx_byte;
        end

        res.card_ready = ready_next;
        res.card_v2    = v2_next;
    end

endmodule

FILE: rtl/sd_spi_host_sequencer_unit.sv
`timescale 1ns / 1ps
// SD card SPI-mode host sequencer. Each input transaction is either a request
// (init, read, write) or the byte the card returned for the last exchange; each
// produces exactly one result naming the next byte to shift out and the chip-select
// level. The sequencer state steps in the cycle a transaction is accepted and the
// result is held in an output register, so one transaction is taken every cycle
// while the output register is empty or being drained; the rate is set by the single
// state update between the input handshake and that register. The user must program
// limits over the APB port only while no operation is in flight; nothing enforces it.
module sd_spi_host_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] sector,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  wr_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        cs_level,
    output logic        rd_valid,
    output logic [7:0]  rd_byte,
    output logic        wr_taken,
    output logic        op_done,
    output logic        op_status,
    output logic        card_ready,
    output logic        card_v2
);

    sdsh_pkg::cfg_t    cfg;
    sdsh_pkg::result_t res_next;
    sdsh_pkg::result_t res_reg;
    logic              valid_reg;
    logic              step;

    assign in_ready = !valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    sdsh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdsh_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .req_type (req_type),
        .sector   (sector),
        .rx_byte  (rx_byte),
        .wr_byte  (wr_byte),
        .cfg      (cfg),
        .res      (res_next)
    );

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (step)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign out_valid  = valid_reg;
    assign tx_byte    = res_reg.tx_byte;
    assign cs_level   = res_reg.cs_level;
    assign rd_valid   = res_reg.rd_valid;
    assign rd_byte    = res_reg.rd_byte;
    assign wr_taken   = res_reg.wr_taken;
    assign op_done    = res_reg.op_done;
    assign op_status  = res_reg.op_status;
    assign card_ready = res_reg.card_ready;
    assign card_v2    = res_reg.card_v2;

endmodule

FILE: rtl/sdsh_checker.sv
`timescale 1ns / 1ps
module sdsh_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] tx_byte,
    input logic       cs_level,
    input logic       rd_valid,
    input logic [7:0] rd_byte,
    input logic       wr_taken,
    input logic       op_done,
    input logic       op_status
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(op_done))
        else $error("result changed while stalled");

    // An accepted input always produces a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted transaction produced no result");

    // The finishing byte is always a deselected 0xFF.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_done |-> cs_level && tx_byte == 8'hFF && !rd_valid && !wr_taken)
        else $error("done byte not a deselect");

    // Status and read data are zero when not flagged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (op_done || !op_status) && (rd_valid || rd_byte == 8'd0))
        else $error("unflagged field not zero");

endmodule

bind sd_spi_host_sequencer_unit sdsh_checker u_sdsh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_byte   (tx_byte),
    .cs_level  (cs_level),
    .rd_valid  (rd_valid),
    .rd_byte   (rd_byte),
    .wr_taken  (wr_taken),
    .op_done   (op_done),
    .op_status (op_status)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import sdsh_pkg::*;

    // One input transaction as the driver presents it.
    typedef struct {
        req_t        req;
        logic [31:0] sector;
        logic [7:0]  rx;
        logic [7:0]  wr;
    } card_item_t;

    // Programmed limits plus the sequencer's own state.
    typedef struct {
        int unsigned cmd_lim, rw_lim, tok_lim, busy_lim, rst_lim, act_lim, dr_lim;
        phase_t      ph;
        int unsigned idx, poll, retry;
        bit          ready, v2;
        logic [31:0] addr;
        logic [7:0]  last_resp;
        cmd_t        cur;
        bit          wr;
    } card_model_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_BYTE;
    logic [31:0] sector = '0;
    logic [7:0]  rx_byte = '0, wr_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  tx_byte, rd_byte;
    logic        cs_level, rd_valid, wr_taken, op_done, op_status, card_ready, card_v2;

    card_model_t  chk_card, gen_card;
    card_item_t   pend_q[$];
    result_t      exp_q[$];
    card_item_t   cur_item;
    int unsigned  gap_left = 0, stall_left = 0;
    int unsigned  n_acc = 0, n_rcv = 0, n_res = 0;
    int unsigned  n_ok = 0, n_fail = 0, n_rd = 0, n_wr = 0, errors = 0;
    bit           hold_long = 1'b0;
    bit           free_slot;

    sd_spi_host_sequencer_unit dut (.*);

    always #2 clk = ~clk;

    // Next byte to send and the sequencer's move to a new phase.
    function automatic void put(inout card_model_t m, inout result_t r, input logic [7:0] tx,
                                input logic cs, input phase_t ph, input int unsigned idx);
        r.tx_byte  = tx;
        r.cs_level = cs;
        m.ph       = ph;
        m.idx      = idx & 10'h3FF;
    endfunction

    // Trailing deselect byte that closes an operation.
    function automatic void close_op(inout card_model_t m, inout result_t r, input logic err);
        r.tx_byte   = 8'hFF;
        r.cs_level  = 1'b1;
        r.op_done   = 1'b1;
        r.op_status = err;
        m.ph        = PH_IDLE;
        m.idx       = 0;
    endfunction

    function automatic logic [7:0] init_frame_byte(input cmd_t c, input int unsigned k);
        logic [7:0]  code;
        logic [31:0] arg;
        logic [7:0]  crc;
        arg = 32'h0;
        crc = 8'hFF;
        case (c)
            CMD_GO_IDLE:  begin code = 8'd0;  crc = 8'h95; end
            CMD_IF_COND:  begin code = 8'd8;  arg = 32'h1AA; crc = 8'h87; end
            CMD_APP:      code = 8'd55;
            CMD_ACTIVATE: begin code = 8'd41; arg = 32'h4000_0000; end
            CMD_READ_OCR: code = 8'd58;
            default:      begin code = 8'd16; arg = SECTOR_BYTES; end
        endcase
        if (k == 0)
            return 8'h40 | code;
        if (k <= 4)
            return 8'(arg >> (8 * (4 - k)));
        return crc;
    endfunction

    function automatic logic [7:0] rw_frame_byte(input card_model_t m, input int unsigned k);
        if (k == 0)
            return m.wr ? 8'h58 : 8'h51;
        if (k <= 4)
            return 8'(m.addr >> (8 * (4 - k)));
        return 8'hFF;
    endfunction

    function automatic bit poll_out(inout card_model_t m, input int unsigned lim);
        m.poll = (m.poll + 1) & 20'hFFFFF;
        return m.poll >= lim;
    endfunction

    // Decide what follows an initialisation command's response.
    function automatic void conclude_cmd(inout card_model_t m, inout result_t r);
        logic [7:0] resp;
        cmd_t       nxt;
        bit         fail;
        bit         fin;
        resp = m.last_resp;
        nxt  = m.cur;
        fail = 1'b0;
        fin  = 1'b0;
        case (m.cur)
            CMD_GO_IDLE:
                if (resp == 8'h01)
                    nxt = CMD_IF_COND;
                else
                begin
                    m.retry = (m.retry + 1) & 12'hFFF;
                    if (m.retry >= m.rst_lim)
                        fail = 1'b1;
                end
            CMD_IF_COND:
                if (resp == 8'h05 || resp == 8'h01)
                begin
                    m.v2 = (resp == 8'h01);
                    m.retry = 0;
                    nxt = CMD_APP;
                end
                else
                    fail = 1'b1;
            CMD_APP:
                nxt = CMD_ACTIVATE;
            CMD_ACTIVATE:
                if (resp == 8'h00)
                    nxt = CMD_READ_OCR;
                else if (resp == 8'h01)
                begin
                    m.retry = (m.retry + 1) & 12'hFFF;
                    if (m.retry >= m.act_lim)
                        fail = 1'b1;
                    else
                        nxt = CMD_APP;
                end
                else
                    fail = 1'b1;
            CMD_READ_OCR:
                if (resp == 8'h00)
                    nxt = CMD_BLOCKLEN;
                else
                    fail = 1'b1;
            default:
                if (resp == 8'h00)
                begin
                    m.ready = 1'b1;
                    close_op(m, r, 1'b0);
                    fin = 1'b1;
                end
                else
                    fail = 1'b1;
        endcase
        if (fail)
            close_op(m, r, 1'b1);
        else if (!fin)
        begin
            m.cur = nxt;
            put(m, r, 8'hFF, 1'b1, PH_CEND, 0);
        end
    endfunction

    // R7 and OCR responses carry four extra bytes before the command is concluded.
    function automatic void cmd_reply(inout card_model_t m, inout result_t r,
                                      input logic [7:0] v);
        m.last_resp = v;
        if ((m.cur == CMD_IF_COND && v == 8'h01) || (m.cur == CMD_READ_OCR && v == 8'h00))
            put(m, r, 8'hFF, 1'b0, PH_CEXTRA, 0);
        else
            conclude_cmd(m, r);
    endfunction

    // Expected result of one transaction; advances the model.
    function automatic result_t predict(inout card_model_t m, input card_item_t it);
        result_t     r;
        int unsigned k;
        r = '0;
        r.tx_byte = 8'hFF;
        r.cs_level = 1'b1;
        k = m.idx;
        if (it.req == REQ_INIT)
        begin
            if (m.ready)
                close_op(m, r, 1'b0);
            else
            begin
                m.retry = 0;
                put(m, r, 8'hFF, 1'b1, PH_PRE, 0);
            end
        end
        else if (it.req != REQ_BYTE)
        begin
            if (!m.ready)
                close_op(m, r, 1'b1);
            else
            begin
                m.wr = (it.req == REQ_WRITE);
                m.addr = m.v2 ? it.sector : (it.sector << 9);
                put(m, r, 8'hFF, 1'b1, PH_XPRE, 0);
            end
        end
        else
        begin
            case (m.ph)
                PH_PRE:
                    if (k + 1 < PREAMBLE_BYTES)
                        put(m, r, 8'hFF, 1'b1, PH_PRE, k + 1);
                    else
                    begin
                        m.retry = 0;
                        m.cur = CMD_GO_IDLE;
                        put(m, r, 8'hFF, 1'b1, PH_CGAP, 0);
                    end
                PH_CGAP:
                    if (k < 7)
                        put(m, r, 8'hFF, 1'b1, PH_CGAP, k + 1);
                    else
                        put(m, r, 8'hFF, 1'b0, PH_CLEAD, 0);
                PH_CLEAD:
                    put(m, r, init_frame_byte(m.cur, 0), 1'b0, PH_CBYTE, 0);
                PH_CBYTE:
                    if (k < 5)
                        put(m, r, init_frame_byte(m.cur, k + 1), 1'b0, PH_CBYTE, k + 1);
                    else
                    begin
                        m.poll = 0;
                        put(m, r, 8'hFF, 1'b0, PH_CPOLL, 0);
                    end
                PH_CPOLL:
                    if (it.rx != 8'hFF)
                        cmd_reply(m, r, it.rx);
                    else if (poll_out(m, m.cmd_lim))
                        cmd_reply(m, r, 8'hFF);
                    else
                        put(m, r, 8'hFF, 1'b0, PH_CPOLL, 0);
                PH_CEXTRA:
                    if (k < 3)
                        put(m, r, 8'hFF, 1'b0, PH_CEXTRA, k + 1);
                    else
                        conclude_cmd(m, r);
                PH_CEND:
                    put(m, r, 8'hFF, 1'b1, PH_CGAP, 0);
                PH_XPRE:
                    put(m, r, rw_frame_byte(m, 0), 1'b0, PH_XBYTE, 0);
                PH_XBYTE:
                    if (k < 5)
                        put(m, r, rw_frame_byte(m, k + 1), 1'b0, PH_XBYTE, k + 1);
                    else
                    begin
                        m.poll = 0;
                        put(m, r, 8'hFF, 1'b0, PH_XPOLL, 0);
                    end
                PH_XPOLL:
                    if (!it.rx[7])
                    begin
                        m.last_resp = it.rx;
                        if (it.rx != 8'h00)
                            close_op(m, r, 1'b1);
                        else if (m.wr)
                            put(m, r, 8'hFE, 1'b0, PH_WTOK, 0);
                        else
                        begin
                            m.poll = 0;
                            put(m, r, 8'hFF, 1'b0, PH_RTOK, 0);
                        end
                    end
                    else if (poll_out(m, m.rw_lim))
                    begin
                        m.last_resp = 8'hFF;
                        close_op(m, r, 1'b1);
                    end
                    else
                        put(m, r, 8'hFF, 1'b0, PH_XPOLL, 0);
                PH_RTOK:
                    if (it.rx != 8'hFF)
                    begin
                        if (it.rx == 8'hFE)
                            put(m, r, 8'hFF, 1'b0, PH_RDATA, 0);
                        else
                            close_op(m, r, 1'b1);
                    end
                    else if (poll_out(m, m.tok_lim))
                        close_op(m, r, 1'b1);
                    else
                        put(m, r, 8'hFF, 1'b0, PH_RTOK, 0);
                PH_RDATA:
                begin
                    r.rd_valid = 1'b1;
                    r.rd_byte = it.rx;
                    if (k < SECTOR_BYTES - 1)
                        put(m, r, 8'hFF, 1'b0, PH_RDATA, k + 1);
                    else
                        put(m, r, 8'hFF, 1'b0, PH_RCRC, 0);
                end
                PH_RCRC:
                    if (k == 0)
                        put(m, r, 8'hFF, 1'b0, PH_RCRC, 1);
                    else
                        close_op(m, r, 1'b0);
                PH_WTOK:
                begin
                    put(m, r, it.wr, 1'b0, PH_WDATA, 0);
                    r.wr_taken = 1'b1;
                end
                PH_WDATA:
                    if (k < SECTOR_BYTES - 1)
                    begin
                        put(m, r, it.wr, 1'b0, PH_WDATA, k + 1);
                        r.wr_taken = 1'b1;
                    end
                    else
                        put(m, r, 8'h00, 1'b0, PH_WCRC, 0);
                PH_WCRC:
                    if (k == 0)
                        put(m, r, 8'h00, 1'b0, PH_WCRC, 1);
                    else
                    begin
                        m.poll = 0;
                        put(m, r, 8'hFF, 1'b0, PH_WRESP, 0);
                    end
                PH_WRESP:
                    if (it.rx != 8'hFF)
                    begin
                        if (it.rx[4:0] == 5'h05)
                        begin
                            m.poll = 0;
                            put(m, r, 8'hFF, 1'b0, PH_WBUSY, 0);
                        end
                        else
                            close_op(m, r, 1'b1);
                    end
                    else if (poll_out(m, m.dr_lim))
                        close_op(m, r, 1'b1);
                    else
                        put(m, r, 8'hFF, 1'b0, PH_WRESP, 0);
                PH_WBUSY:
                    if (it.rx != 8'h00)
                        close_op(m, r, 1'b0);
                    else if (poll_out(m, m.busy_lim))
                        close_op(m, r, 1'b1);
                    else
                        put(m, r, 8'hFF, 1'b0, PH_WBUSY, 0);
                default:
                    put(m, r, 8'hFF, 1'b1, PH_IDLE, 0);
            endcase
        end
        r.card_ready = m.ready;
        r.card_v2 = m.v2;
        return r;
    endfunction

    function automatic void apply_limit(inout card_model_t m, input reg_idx_t ri,
                                        input int unsigned v);
        case (ri)
            REG_CMD_POLL:    m.cmd_lim  = v & 16'hFFFF;
            REG_RW_POLL:     m.rw_lim   = v & 16'hFFFF;
            REG_TOKEN_POLL:  m.tok_lim  = v & 20'hFFFFF;
            REG_BUSY_POLL:   m.busy_lim = v & 20'hFFFFF;
            REG_RESET_RETRY: m.rst_lim  = v & 12'hFFF;
            REG_ACT_RETRY:   m.act_lim  = v & 8'hFF;
            default:         m.dr_lim   = v & 8'hFF;
        endcase
    endfunction

    // Choose the next transaction so that it mostly plays a well-behaved card.
    function automatic card_item_t pick(input card_model_t g);
        card_item_t  it;
        int unsigned d;
        it.req = REQ_BYTE;
        it.sector = $urandom;
        it.rx = 8'($urandom);
        it.wr = 8'($urandom);
        d = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0)
            it.sector = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        if (g.ph != PH_IDLE && $urandom_range(0, 499) == 0)
            it.req = req_t'($urandom_range(1, 3));
        else
        begin
            case (g.ph)
                PH_IDLE:
                    if (!g.ready)
                        it.req = (d < 85) ? REQ_INIT : req_t'($urandom_range(0, 3));
                    else
                        it.req = (d < 40) ? REQ_READ : (d < 80) ? REQ_WRITE :
                                 (d < 90) ? REQ_INIT : REQ_BYTE;
                PH_CPOLL:
                    if (d < 25)
                        it.rx = 8'hFF;
                    else if (d >= 33)
                    begin
                        case (g.cur)
                            CMD_GO_IDLE:  it.rx = 8'h01;
                            CMD_IF_COND:  it.rx = $urandom_range(0, 1) ? 8'h01 : 8'h05;
                            CMD_APP:      it.rx = 8'($urandom);
                            CMD_ACTIVATE: it.rx = ($urandom_range(0, 2) == 0) ? 8'h01 : 8'h00;
                            default:      it.rx = 8'h00;
                        endcase
                    end
                PH_XPOLL:
                    if (d < 25)
                        it.rx = it.rx | 8'h80;
                    else if (d >= 30)
                        it.rx = 8'h00;
                PH_RTOK:
                    if (d < 25)
                        it.rx = 8'hFF;
                    else if (d >= 30)
                        it.rx = 8'hFE;
                PH_WRESP:
                    if (d < 25)
                        it.rx = 8'hFF;
                    else if (d >= 30)
                        it.rx = {it.rx[7:5], 5'h05};
                PH_WBUSY:
                    if (d < 30)
                        it.rx = 8'h00;
                    else if (it.rx == 8'h00)
                        it.rx = 8'h01;
                default:
                    ;
            endcase
        end
        return it;
    endfunction

    task automatic queue_item(input card_item_t it);
        result_t discard;
        pend_q.push_back(it);
        discard = predict(gen_card, it);
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || in_valid || exp_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // APB write: setup cycle, then the access cycle commits the register.
    task automatic program_limit(input reg_idx_t ri, input int unsigned v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ri, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_limit(chk_card, ri, v);
        apply_limit(gen_card, ri, v);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Driver: presents queued transactions with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            free_slot = !in_valid;
            if (in_valid && in_ready)
            begin
                exp_q.push_back(predict(chk_card, cur_item));
                n_acc++;
                free_slot = 1'b1;
            end
            if (free_slot)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() > 0)
                begin
                    cur_item = pend_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= cur_item.req;
                    sector   <= cur_item.sector;
                    rx_byte  <= cur_item.rx;
                    wr_byte  <= cur_item.wr;
                    gap_left = (n_acc % 250 < 50) ? 0 : $urandom_range(0, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls after each transaction, plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_rcv++;
                stall_left = (n_rcv % 300 < 60) ? 0 : $urandom_range(0, 3);
            end
            else if (stall_left > 0)
                stall_left--;
            out_ready <= (stall_left == 0) && !hold_long;
        end
    end

    // Monitor: compares every result with the oldest prediction.
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_res++;
            if (exp_q.size() == 0)
            begin
                $error("result with no prediction waiting: tx_byte %h", tx_byte);
                errors++;
            end
            else
            begin
                e = exp_q.pop_front();
                check_field("tx_byte", e.tx_byte, tx_byte);
                check_field("cs_level", e.cs_level, cs_level);
                check_field("rd_valid", e.rd_valid, rd_valid);
                check_field("rd_byte", e.rd_byte, rd_byte);
                check_field("wr_taken", e.wr_taken, wr_taken);
                check_field("op_done", e.op_done, op_done);
                check_field("op_status", e.op_status, op_status);
                check_field("card_ready", e.card_ready, card_ready);
                check_field("card_v2", e.card_v2, card_v2);
                if (e.op_done)
                begin
                    if (e.op_status)
                        n_fail++;
                    else
                        n_ok++;
                end
                n_rd += e.rd_valid;
                n_wr += e.wr_taken;
            end
        end
    end

    // Long receiver hold-off so that the output register fills and the input stalls.
    initial
    begin
        while (n_acc < 600)
            @(negedge clk);
        hold_long = 1'b1;
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Stimulus: directed corner cases, then random phases under several limit settings.
    initial
    begin
        int unsigned lims[4][7];
        card_item_t  it;
        lims = '{'{3, 3, 4, 4, 3, 3, 3},
                 '{1, 1, 1, 1, 1, 1, 1},
                 '{65535, 65535, 1048575, 1048575, 4095, 255, 255},
                 '{2, 5, 6, 3, 2, 4, 2}};
        chk_card = '{cmd_lim: 1000, rw_lim: 10000, tok_lim: 1000000, busy_lim: 500000,
                     rst_lim: 4095, act_lim: 5, dr_lim: 20, ph: PH_IDLE, idx: 0, poll: 0,
                     retry: 0, ready: 1'b0, v2: 1'b0, addr: '0, last_resp: 8'hFF,
                     cur: CMD_GO_IDLE, wr: 1'b0};
        gen_card = chk_card;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Idle bytes, read and write before init, and init abandoned by a read request.
        queue_item('{REQ_BYTE, 32'h0, 8'h00, 8'h00});
        queue_item('{REQ_BYTE, 32'hFFFF_FFFF, 8'hFF, 8'hFF});
        queue_item('{REQ_READ, 32'h0, 8'h00, 8'h00});
        queue_item('{REQ_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF});
        queue_item('{REQ_INIT, 32'h0, 8'h00, 8'h00});
        queue_item('{REQ_BYTE, 32'h0, 8'h5A, 8'hA5});
        queue_item('{REQ_BYTE, 32'h0, 8'hA5, 8'h5A});
        queue_item('{REQ_READ, 32'h1234_5678, 8'h00, 8'h00});
        queue_item('{REQ_BYTE, 32'h0, 8'h00, 8'h00});

        for (int s = 0; s < 4; s++)
        begin
            wait_drained();
            for (int i = 0; i < 7; i++)
                program_limit(reg_idx_t'(i), lims[s][i]);
            repeat (280)
                queue_item(pick(gen_card));
            // Bring the sequencer back to idle before the limits change.
            it = pick(gen_card);
            it.req = gen_card.ready ? REQ_INIT : REQ_READ;
            queue_item(it);
        end
        wait_drained();
        repeat (20) @(negedge clk);

        $display("Run covered %0d transactions and %0d results under four limit settings.",
                 n_acc, n_res);
        $display("Operations: %0d ok, %0d failed; %0d sector bytes read, %0d written.",
                 n_ok, n_fail, n_rd, n_wr);
        if (errors == 0 && exp_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
